>>> design/elsm_pkg.sv
// Shared types, codes and reset values for the encoder link stability monitor.
// No dependencies; every other design file refers to it by scoped names.
package elsm_pkg;

  localparam int ANGLE_STEPS_DEF = 4096;
  localparam int ANGLE_W         = 12;
  localparam int COUNT_W         = 32;
  localparam int BURST_W         = 16;
  localparam int JITTER_W        = 13;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [BURST_W-1:0]    BURST_LIMIT_RST  = 16'd3;
  localparam logic [CFG_DATA_W-1:0] RATE_SCALE_RST   = 16'd200;
  localparam logic [JITTER_W-1:0]   JITTER_LIMIT_RST = 13'd8;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BURST_LIMIT  = 2'd0,
    CFG_RATE_SCALE   = 2'd1,
    CFG_JITTER_LIMIT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_STABLE   = 2'd0,
    VERDICT_UNSTABLE = 2'd1,
    VERDICT_MARGINAL = 2'd2
  } verdict_t;

  // Counter snapshot handed from the statistics stage to the judging stage.
  typedef struct packed {
    logic [COUNT_W-1:0] read_count;
    logic [COUNT_W-1:0] error_count;
    logic [BURST_W-1:0] worst_burst;
  } stats_t;

  // Width of the signed offset envelope: room for a raw angle difference
  // plus one wrap step, whichever of angle range and step count is larger.
  function automatic int off_width(input int steps);
    int lg;
    lg = $clog2(steps);
    if (lg < ANGLE_W) lg = ANGLE_W;
    return lg + 2;
  endfunction

endpackage

>>> design/elsm_stats.sv
// Statistics state of the encoder link stability monitor: counters, burst
// tracking, reference angle and offset envelope. Uses elsm_pkg.
module elsm_stats #(
  parameter int ANGLE_STEPS = elsm_pkg::ANGLE_STEPS_DEF,
  parameter int OFF_W       = elsm_pkg::off_width(ANGLE_STEPS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               take,
  input  logic                               cmd,
  input  logic                               read_failed,
  input  logic [elsm_pkg::ANGLE_W-1:0]       angle,
  output elsm_pkg::stats_t                   stats,
  output logic signed [OFF_W-1:0]            off_low,
  output logic signed [OFF_W-1:0]            off_high
);

  localparam logic signed [OFF_W-1:0] STEPS_S = OFF_W'(ANGLE_STEPS);
  localparam logic signed [OFF_W-1:0] HALF_S  = OFF_W'(ANGLE_STEPS / 2);
  localparam logic signed [OFF_W-1:0] NHALF_S = -HALF_S;

  logic [elsm_pkg::COUNT_W-1:0] read_r, read_nxt;
  logic [elsm_pkg::COUNT_W-1:0] err_r, err_nxt;
  logic [elsm_pkg::BURST_W-1:0] worst_r, worst_nxt;
  logic [elsm_pkg::BURST_W-1:0] cur_r, cur_nxt;
  logic [elsm_pkg::ANGLE_W-1:0] ref_r, ref_nxt;
  logic                         ref_valid_r, ref_valid_nxt;
  logic signed [OFF_W-1:0]      low_r, low_nxt;
  logic signed [OFF_W-1:0]      high_r, high_nxt;
  logic signed [OFF_W-1:0]      diff, diff_w;

  always_comb begin
    diff = $signed({{(OFF_W-elsm_pkg::ANGLE_W){1'b0}}, angle})
         - $signed({{(OFF_W-elsm_pkg::ANGLE_W){1'b0}}, ref_r});
    // single wrap correction toward the short way around
    if (diff > HALF_S) begin
      diff_w = diff - STEPS_S;
    end else if (diff < NHALF_S) begin
      diff_w = diff + STEPS_S;
    end else begin
      diff_w = diff;
    end
  end

  always_comb begin
    read_nxt      = read_r;
    err_nxt       = err_r;
    worst_nxt     = worst_r;
    cur_nxt       = cur_r;
    ref_nxt       = ref_r;
    ref_valid_nxt = ref_valid_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    if (cmd == elsm_pkg::CMD_CLEAR) begin
      read_nxt      = '0;
      err_nxt       = '0;
      worst_nxt     = '0;
      cur_nxt       = '0;
      ref_nxt       = '0;
      ref_valid_nxt = 1'b0;
      low_nxt       = STEPS_S;
      high_nxt      = -STEPS_S;
    end else begin
      if (read_r != '1) read_nxt = read_r + 1'b1;
      if (read_failed) begin
        if (err_r != '1) err_nxt = err_r + 1'b1;
        if (cur_r != '1) cur_nxt = cur_r + 1'b1;
        if (cur_nxt > worst_r) worst_nxt = cur_nxt;
      end else begin
        cur_nxt = '0;
        if (!ref_valid_r) begin
          ref_nxt       = angle;
          ref_valid_nxt = 1'b1;
        end else begin
          if (diff_w < low_r)  low_nxt  = diff_w;
          if (diff_w > high_r) high_nxt = diff_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_r      <= '0;
      err_r       <= '0;
      worst_r     <= '0;
      cur_r       <= '0;
      ref_r       <= '0;
      ref_valid_r <= 1'b0;
      low_r       <= STEPS_S;
      high_r      <= -STEPS_S;
    end else if (take) begin
      read_r      <= read_nxt;
      err_r       <= err_nxt;
      worst_r     <= worst_nxt;
      cur_r       <= cur_nxt;
      ref_r       <= ref_nxt;
      ref_valid_r <= ref_valid_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
  end

  assign stats.read_count  = read_r;
  assign stats.error_count = err_r;
  assign stats.worst_burst = worst_r;
  assign off_low           = low_r;
  assign off_high          = high_r;

endmodule

>>> design/elsm_judge.sv
// Judging logic: error-rate product, burst and jitter compares, then verdict
// and jitter warning into the result register. Uses elsm_pkg.
module elsm_judge #(
  parameter int OFF_W = elsm_pkg::off_width(elsm_pkg::ANGLE_STEPS_DEF)
) (
  input  logic                              clk,
  input  logic                              load_out,
  input  elsm_pkg::stats_t                  stats,
  input  logic signed [OFF_W-1:0]           off_low,
  input  logic signed [OFF_W-1:0]           off_high,
  input  logic [elsm_pkg::BURST_W-1:0]      burst_limit,
  input  logic [elsm_pkg::CFG_DATA_W-1:0]   rate_scale,
  input  logic [elsm_pkg::JITTER_W-1:0]     jitter_limit,
  output elsm_pkg::stats_t                  res_stats,
  output logic [elsm_pkg::JITTER_W-1:0]     res_jitter,
  output elsm_pkg::verdict_t                res_verdict,
  output logic                              res_warn
);

  localparam int PROD_W = elsm_pkg::COUNT_W + elsm_pkg::CFG_DATA_W;

  logic [PROD_W-1:0]   prod;
  logic [OFF_W:0]      jit_nxt;
  logic                rate_hit;
  logic                burst_hit;
  logic                warn_nxt;
  elsm_pkg::verdict_t  verdict_nxt;

  elsm_pkg::stats_t    out_stats_r;
  logic [elsm_pkg::JITTER_W-1:0] out_jit_r;
  elsm_pkg::verdict_t  out_verdict_r;
  logic                out_warn_r;

  always_comb begin
    if (off_high >= off_low) begin
      jit_nxt = (OFF_W + 1)'($signed({off_high[OFF_W-1], off_high})
                           - $signed({off_low[OFF_W-1], off_low}));
    end else begin
      jit_nxt = '0;
    end
  end

  always_comb begin
    prod      = PROD_W'(stats.error_count) * PROD_W'(rate_scale);
    rate_hit  = (prod >= PROD_W'(stats.read_count)) && (rate_scale != '0);
    burst_hit = stats.worst_burst >= burst_limit;
    warn_nxt  = jit_nxt > (OFF_W + 1)'(jitter_limit);
    if (stats.error_count == '0) begin
      verdict_nxt = elsm_pkg::VERDICT_STABLE;
    end else if (rate_hit || burst_hit) begin
      verdict_nxt = elsm_pkg::VERDICT_UNSTABLE;
    end else begin
      verdict_nxt = elsm_pkg::VERDICT_MARGINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_stats_r   <= stats;
      out_jit_r     <= jit_nxt[elsm_pkg::JITTER_W-1:0];
      out_verdict_r <= verdict_nxt;
      out_warn_r    <= warn_nxt;
    end
  end

  assign res_stats   = out_stats_r;
  assign res_jitter  = out_jit_r;
  assign res_verdict = out_verdict_r;
  assign res_warn    = out_warn_r;

endmodule

>>> design/encoder_link_stability_monitor.sv
// Top level of the encoder link stability monitor: stream ports, register
// file and pipeline valid control. Uses elsm_pkg, elsm_stats, elsm_judge.
//
//   channel | direction | carries
//   --------+-----------+---------------------------------------------------
//   in_     | sink      | one encoder sample or a clear command per transfer
//   out_    | source    | counts, jitter, verdict and warning per sample
//   cfg_    | sink      | register index and data; always ready
//
// Every cycle one sample can be taken while in_tready is high. The statistics
// registers are updated at the accept edge and act as the input register; the
// judging logic feeds the output register once that register can take the
// snapshot, and out_tvalid rises when it loads. The statistics stage holds
// while the output register is full and stalled, so in_tready drops only once
// both are full. Synchronous reset clears statistics, registers to their
// defaults and both stage valids.
module encoder_link_stability_monitor #(
  parameter int ANGLE_STEPS = elsm_pkg::ANGLE_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,   // [11:0] angle
  input  logic [1:0]                          in_tuser,   // [0] cmd, [1] read_failed
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] read_total, [63:32] error_total, [79:64] worst_run,
  // [92:80] jitter_pp, [94:93] verdict, [95] jitter_warn
  output logic [95:0]                         out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [elsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [elsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int OFF_W = elsm_pkg::off_width(ANGLE_STEPS);

  // configuration registers
  logic [elsm_pkg::BURST_W-1:0]    burst_limit_r;
  logic [elsm_pkg::CFG_DATA_W-1:0] rate_scale_r;
  logic [elsm_pkg::JITTER_W-1:0]   jitter_limit_r;

  // stage valids: statistics snapshot, output register
  logic stat_valid_r, stat_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  logic take, load_out;
  logic out_ready_int;

  elsm_pkg::stats_t        stats, res_stats;
  logic signed [OFF_W-1:0] off_low, off_high;
  logic [elsm_pkg::JITTER_W-1:0] res_jitter;
  elsm_pkg::verdict_t      res_verdict;
  logic                    res_warn;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r  <= elsm_pkg::BURST_LIMIT_RST;
      rate_scale_r   <= elsm_pkg::RATE_SCALE_RST;
      jitter_limit_r <= elsm_pkg::JITTER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        elsm_pkg::CFG_BURST_LIMIT:  burst_limit_r  <= cfg_data;
        elsm_pkg::CFG_RATE_SCALE:   rate_scale_r   <= cfg_data;
        elsm_pkg::CFG_JITTER_LIMIT: jitter_limit_r <= cfg_data[elsm_pkg::JITTER_W-1:0];
        default: ; // drop writes past the register list
      endcase
    end
  end

  // ready ripples back from the output register to the statistics stage
  assign out_ready_int = !out_valid_r || out_tready;
  assign in_tready     = !stat_valid_r || out_ready_int;

  assign take     = in_tvalid && in_tready;
  assign load_out = stat_valid_r && out_ready_int;

  always_comb begin
    stat_valid_nxt = take ? 1'b1 : (load_out ? 1'b0 : stat_valid_r);
    out_valid_nxt  = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      stat_valid_r <= stat_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // The statistics registers double as the first stage: a new sample only
  // lands when the previous snapshot moves into the output register at the
  // same edge or has already gone.
  elsm_stats #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .OFF_W       (OFF_W)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .cmd         (in_tuser[0]),
    .read_failed (in_tuser[1]),
    .angle       (in_tdata[elsm_pkg::ANGLE_W-1:0]),
    .stats       (stats),
    .off_low     (off_low),
    .off_high    (off_high)
  );

  elsm_judge #(
    .OFF_W (OFF_W)
  ) u_judge (
    .clk          (clk),
    .load_out     (load_out),
    .stats        (stats),
    .off_low      (off_low),
    .off_high     (off_high),
    .burst_limit  (burst_limit_r),
    .rate_scale   (rate_scale_r),
    .jitter_limit (jitter_limit_r),
    .res_stats    (res_stats),
    .res_jitter   (res_jitter),
    .res_verdict  (res_verdict),
    .res_warn     (res_warn)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_warn, res_verdict, res_jitter, res_stats.worst_burst,
                       res_stats.error_count, res_stats.read_count};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_link_stability_monitor: directed table, random
// encoder traffic and register sweeps, checked against an in-bench predictor.
// Depends on elsm_pkg and the encoder_link_stability_monitor RTL only.
module testbench;

  localparam int   STEPS           = elsm_pkg::ANGLE_STEPS_DEF;
  localparam int   HALF_TURN       = STEPS / 2;
  localparam int   HOLD_OFF_CYCLES = 40;
  localparam int   LONG_FAIL_RUN   = 40;
  localparam int   DIRECTED_ROWS   = 23;
  localparam logic READ_OK         = 1'b0;
  localparam logic READ_FAILED     = 1'b1;
  localparam logic [elsm_pkg::CFG_INDEX_W-1:0] UNUSED_REG_INDEX = 2'd3;

  // Short aliases that keep the directed table readable.
  localparam logic               SAMPLE     = elsm_pkg::CMD_SAMPLE;
  localparam logic               CLEAR      = elsm_pkg::CMD_CLEAR;
  localparam elsm_pkg::verdict_t V_STABLE   = elsm_pkg::VERDICT_STABLE;
  localparam elsm_pkg::verdict_t V_UNSTABLE = elsm_pkg::VERDICT_UNSTABLE;

  // Same bit order as out_tdata, so a report can be cast straight off the bus.
  typedef struct packed {
    logic                          jitter_warn;
    elsm_pkg::verdict_t            verdict;
    logic [elsm_pkg::JITTER_W-1:0] jitter_pp;
    logic [elsm_pkg::BURST_W-1:0]  worst_run;
    logic [elsm_pkg::COUNT_W-1:0]  error_total;
    logic [elsm_pkg::COUNT_W-1:0]  read_total;
  } link_report_t;

  typedef struct packed {
    logic                         cmd;
    logic                         failed;
    logic [elsm_pkg::ANGLE_W-1:0] angle;
    logic                         typed;      // 1: take want as typed below, 0: use the predictor
    link_report_t                 want;
  } sample_row_t;

  localparam link_report_t CLEARED = '0;
  localparam link_report_t UNTYPED = '0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [elsm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [elsm_pkg::CFG_DATA_W-1:0]  cfg_data;

  encoder_link_stability_monitor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [11:0] angle
    .in_tuser   (in_tuser),    // [0] cmd, [1] read_failed
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // read_total, error_total, worst_run, jitter_pp, verdict, warn
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the link statistics and of the three registers.
  // ---------------------------------------------------------------------------
  logic [elsm_pkg::COUNT_W-1:0]    exp_reads, exp_errors;
  logic [elsm_pkg::BURST_W-1:0]    exp_worst, exp_run;
  logic [elsm_pkg::ANGLE_W-1:0]    exp_ref;
  logic                            exp_ref_ok;
  int                              exp_low, exp_high;
  logic [elsm_pkg::BURST_W-1:0]    exp_burst_limit;
  logic [elsm_pkg::CFG_DATA_W-1:0] exp_rate_scale;
  logic [elsm_pkg::JITTER_W-1:0]   exp_jitter_limit;

  link_report_t pending_reports[$];   // one per accepted sample, oldest first

  // Test-shape controls shared with the result sink.
  bit idle_enable   = 1'b1;
  int hold_requests = 0;

  int mismatches, reports_checked, samples_sent, clears_sent, settings_applied;
  int input_held_cycles;
  int seen_stable, seen_unstable, seen_marginal;

  function automatic void clear_link_stats();
    exp_reads  = '0;
    exp_errors = '0;
    exp_worst  = '0;
    exp_run    = '0;
    exp_ref    = '0;
    exp_ref_ok = 1'b0;
    exp_low    = STEPS;
    exp_high   = -STEPS;
  endfunction

  // Advance the statistics by one transfer and return the report it yields.
  function automatic link_report_t next_link_report(input logic cmd, input logic failed,
                                                    input logic [elsm_pkg::ANGLE_W-1:0] angle);
    int           offset;
    int           spread;
    link_report_t r;
    if (cmd == elsm_pkg::CMD_CLEAR) begin
      clear_link_stats();
    end else begin
      if (exp_reads != '1) exp_reads++;
      if (failed) begin
        if (exp_errors != '1) exp_errors++;
        if (exp_run != '1) exp_run++;
        if (exp_run > exp_worst) exp_worst = exp_run;
      end else begin
        exp_run = '0;
        if (!exp_ref_ok) begin
          // first good angle only becomes the reference
          exp_ref    = angle;
          exp_ref_ok = 1'b1;
        end else begin
          // fold the difference into one turn, exactly half a turn stays as is
          offset = int'(angle) - int'(exp_ref);
          if (offset > HALF_TURN) offset -= STEPS;
          if (offset < -HALF_TURN) offset += STEPS;
          if (offset < exp_low) exp_low = offset;
          if (offset > exp_high) exp_high = offset;
        end
      end
    end
    spread = (exp_high >= exp_low) ? exp_high - exp_low : 0;
    r.read_total  = exp_reads;
    r.error_total = exp_errors;
    r.worst_run   = exp_worst;
    r.jitter_pp   = spread[elsm_pkg::JITTER_W-1:0];
    r.jitter_warn = (spread > int'(exp_jitter_limit));
    if (exp_errors == '0)
      r.verdict = elsm_pkg::VERDICT_STABLE;
    else if (exp_rate_scale != '0 &&
             64'(exp_errors) * 64'(exp_rate_scale) >= 64'(exp_reads))
      r.verdict = elsm_pkg::VERDICT_UNSTABLE;
    else if (exp_worst >= exp_burst_limit)
      r.verdict = elsm_pkg::VERDICT_UNSTABLE;
    else
      r.verdict = elsm_pkg::VERDICT_MARGINAL;
    return r;
  endfunction

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(99) < 85) ? int'($urandom_range(3, 1)) : int'($urandom_range(30, 10));
  endfunction

  function automatic int sender_gap();
    if (!idle_enable || $urandom_range(99) >= 30) return 0;
    return idle_len();
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one sample after an optional gap; hold it until the transfer happens.
  task automatic send_sample(input logic cmd, input logic failed,
                             input logic [elsm_pkg::ANGLE_W-1:0] angle, input int gap,
                             input logic typed, input link_report_t want);
    link_report_t predicted;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {failed, cmd};
    in_tdata  <= {4'b0000, angle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = next_link_report(cmd, failed, angle);
    pending_reports.push_back(typed ? want : predicted);
    samples_sent++;
    if (cmd == elsm_pkg::CMD_CLEAR) clears_sent++;
  endtask

  // Pause the sender until every outstanding report has been checked.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Leaves cfg_valid high so back-to-back writes never drop it within a step.
  task automatic write_reg(input logic [elsm_pkg::CFG_INDEX_W-1:0] index,
                           input logic [elsm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      elsm_pkg::CFG_BURST_LIMIT:  exp_burst_limit  = data;
      elsm_pkg::CFG_RATE_SCALE:   exp_rate_scale   = data;
      elsm_pkg::CFG_JITTER_LIMIT: exp_jitter_limit = data[elsm_pkg::JITTER_W-1:0];
      default: ;   // no register behind this index
    endcase
  endtask

  // Only called with the pipeline empty.
  task automatic program_regs(input logic [elsm_pkg::CFG_DATA_W-1:0] burst,
                              input logic [elsm_pkg::CFG_DATA_W-1:0] rate,
                              input logic [elsm_pkg::CFG_DATA_W-1:0] jitter_data,
                              input bit poke_unused);
    if (poke_unused) write_reg(UNUSED_REG_INDEX, 16'hFFFF);
    write_reg(elsm_pkg::CFG_BURST_LIMIT, burst);
    write_reg(elsm_pkg::CFG_RATE_SCALE, rate);
    write_reg(elsm_pkg::CFG_JITTER_LIMIT, jitter_data);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Random encoder traffic: a wandering angle with adjustable noise, runs of
  // failed reads, stray readings and the occasional clear.
  task automatic run_link_traffic(input int count, input int fail_permille, input int max_burst,
                                  input bit gaps, input bit squeeze);
    logic [elsm_pkg::ANGLE_W-1:0] center, angle;
    logic                         cmd, failed;
    int                           spread, run_left, noise, roll, gap;
    idle_enable <= gaps;
    center   = elsm_pkg::ANGLE_W'($urandom);
    spread   = 4;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      cmd    = elsm_pkg::CMD_SAMPLE;
      failed = READ_OK;
      angle  = elsm_pkg::ANGLE_W'($urandom);
      roll   = $urandom_range(999);
      if (roll < 6) begin
        cmd      = elsm_pkg::CMD_CLEAR;
        failed   = 1'($urandom_range(1));
        run_left = 0;
        center   = elsm_pkg::ANGLE_W'($urandom);
        case ($urandom_range(6))
          0:       spread = 0;
          1:       spread = 1;
          2:       spread = 4;
          3:       spread = 8;
          4:       spread = 40;
          5:       spread = 300;
          default: spread = HALF_TURN;
        endcase
      end else if (run_left > 0 || roll < 6 + fail_permille) begin
        failed   = READ_FAILED;
        run_left = (run_left > 0) ? run_left - 1 : int'($urandom_range(max_burst - 1));
      end else if (roll < 980) begin
        noise = int'($urandom_range(2 * spread)) - spread;
        angle = center + noise[elsm_pkg::ANGLE_W-1:0];
        if ($urandom_range(63) == 0)
          center = ($urandom_range(1) != 0) ? center + 1'b1 : center - 1'b1;
      end
      // otherwise keep the fully random angle as a stray reading

      if ($urandom_range(99) == 0) drain();
      gap = sender_gap();
      // Stall the result side for a long stretch and keep offering back to back,
      // so all stages fill and in_tready must drop.
      if (squeeze && i == count / 2) hold_requests <= hold_requests + 1;
      if (squeeze && i >= count / 2 && i < count / 2 + 20) gap = 0;
      send_sample(cmd, failed, angle, gap, 1'b0, UNTYPED);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. want columns: warn, verdict, jitter_pp, worst_run,
  // error_total, read_total. Registers are at reset values throughout.
  // ---------------------------------------------------------------------------
  sample_row_t directed_rows [DIRECTED_ROWS] = '{
    // first good angle is the reference only
    '{SAMPLE, READ_OK,     12'd0,    1'b1, '{1'b0, V_STABLE,   13'd0,    16'd0, 32'd0, 32'd1}},
    // exactly half a turn stays positive
    '{SAMPLE, READ_OK,     12'd2048, 1'b1, '{1'b0, V_STABLE,   13'd0,    16'd0, 32'd0, 32'd2}},
    // one past half a turn wraps negative: widest envelope
    '{SAMPLE, READ_OK,     12'd2049, 1'b1, '{1'b1, V_STABLE,   13'd4095, 16'd0, 32'd0, 32'd3}},
    '{SAMPLE, READ_OK,     12'd4095, 1'b1, '{1'b1, V_STABLE,   13'd4095, 16'd0, 32'd0, 32'd4}},
    // failed read ignores the angle and leaves the envelope alone
    '{SAMPLE, READ_FAILED, 12'd4095, 1'b1, '{1'b1, V_UNSTABLE, 13'd4095, 16'd1, 32'd1, 32'd5}},
    // clear ignores read_failed and angle
    '{CLEAR,  READ_FAILED, 12'd4095, 1'b1, CLEARED},
    '{SAMPLE, READ_FAILED, 12'd0,    1'b1, '{1'b0, V_UNSTABLE, 13'd0,    16'd1, 32'd1, 32'd1}},
    '{SAMPLE, READ_FAILED, 12'd0,    1'b0, UNTYPED},
    '{SAMPLE, READ_FAILED, 12'd0,    1'b1, '{1'b0, V_UNSTABLE, 13'd0,    16'd3, 32'd3, 32'd3}},
    // reference taken after errors, burst restarts but worst run stays
    '{SAMPLE, READ_OK,     12'd4095, 1'b1, '{1'b0, V_UNSTABLE, 13'd0,    16'd3, 32'd3, 32'd4}},
    // upward wrap across zero
    '{SAMPLE, READ_OK,     12'd0,    1'b1, '{1'b0, V_UNSTABLE, 13'd0,    16'd3, 32'd3, 32'd5}},
    '{SAMPLE, READ_OK,     12'd4094, 1'b1, '{1'b0, V_UNSTABLE, 13'd2,    16'd3, 32'd3, 32'd6}},
    // exactly minus half a turn is not folded
    '{SAMPLE, READ_OK,     12'd2047, 1'b1, '{1'b1, V_UNSTABLE, 13'd2049, 16'd3, 32'd3, 32'd7}},
    '{CLEAR,  READ_OK,     12'd0,    1'b1, CLEARED},
    // jitter right at the limit does not warn, one above does
    '{SAMPLE, READ_OK,     12'd1,    1'b1, '{1'b0, V_STABLE,   13'd0,    16'd0, 32'd0, 32'd1}},
    '{SAMPLE, READ_OK,     12'd9,    1'b1, '{1'b0, V_STABLE,   13'd0,    16'd0, 32'd0, 32'd2}},
    '{SAMPLE, READ_OK,     12'd1,    1'b1, '{1'b0, V_STABLE,   13'd8,    16'd0, 32'd0, 32'd3}},
    '{SAMPLE, READ_OK,     12'd0,    1'b1, '{1'b1, V_STABLE,   13'd9,    16'd0, 32'd0, 32'd4}},
    '{SAMPLE, READ_FAILED, 12'hAAA,  1'b1, '{1'b1, V_UNSTABLE, 13'd9,    16'd1, 32'd1, 32'd5}},
    '{CLEAR,  READ_FAILED, 12'h555,  1'b1, CLEARED},
    '{SAMPLE, READ_OK,     12'hAAA,  1'b0, UNTYPED},
    '{SAMPLE, READ_FAILED, 12'h555,  1'b0, UNTYPED},
    '{SAMPLE, READ_OK,     12'hFFF,  1'b0, UNTYPED}
  };

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus a long hold whenever one is requested.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int served, span;
    served = 0;
    forever begin
      if (served != hold_requests) begin
        served++;
        out_tready <= 1'b0;
        span = HOLD_OFF_CYCLES;
      end else if (idle_enable && $urandom_range(99) < 30) begin
        out_tready <= 1'b0;
        span = idle_len();
      end else begin
        out_tready <= 1'b1;
        span = 1;
      end
      repeat (span) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : report_checker
    link_report_t got, want;
    if (in_tvalid && !in_tready) input_held_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got = link_report_t'(out_tdata);
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with no sample outstanding, tdata=%h",
                   $realtime, out_tdata);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        case (want.verdict)
          elsm_pkg::VERDICT_STABLE:   seen_stable++;
          elsm_pkg::VERDICT_UNSTABLE: seen_unstable++;
          default:                    seen_marginal++;
        endcase
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: report %0d got  reads=%0d errors=%0d worst=%0d jitter=%0d %s%0d warn=%b",
                     $realtime, reports_checked, got.read_total, got.error_total,
                     got.worst_run, got.jitter_pp, "verdict=", got.verdict, got.jitter_warn);
            $display("%0t: report %0d want reads=%0d errors=%0d worst=%0d jitter=%0d %s%0d warn=%b",
                     $realtime, reports_checked, want.read_total, want.error_total,
                     want.worst_run, want.jitter_pp, "verdict=", want.verdict, want.jitter_warn);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    exp_burst_limit  = elsm_pkg::BURST_LIMIT_RST;
    exp_rate_scale   = elsm_pkg::RATE_SCALE_RST;
    exp_jitter_limit = elsm_pkg::JITTER_LIMIT_RST;
    clear_link_stats();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk at reset register values
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_sample(directed_rows[r].cmd, directed_rows[r].failed, directed_rows[r].angle,
                  sender_gap(), directed_rows[r].typed, directed_rows[r].want);
    drain();

    // smallest nonzero limits, zero jitter limit
    program_regs(16'd1, 16'd1, 16'd0, 1'b0);
    run_link_traffic(180, 30, 4, 1'b1, 1'b0);
    drain();

    // largest limits, no idling on either side
    program_regs(16'hFFFF, 16'hFFFF, 16'd4096, 1'b0);
    run_link_traffic(180, 20, 3, 1'b0, 1'b0);
    drain();

    // zero burst and rate limits, all-ones jitter data; also hit the spare index
    program_regs(16'd0, 16'd0, 16'hFFFF, 1'b1);
    run_link_traffic(180, 50, 6, 1'b1, 1'b1);
    drain();

    // moderate settings where marginal links show up
    program_regs(16'd3, 16'd20, 16'd50, 1'b0);
    run_link_traffic(180, 15, 3, 1'b1, 1'b0);
    drain();

    program_regs(16'd2, 16'd5, 16'd300, 1'b0);
    run_link_traffic(200, 80, 5, 1'b1, 1'b0);
    drain();

    // One unbroken run of failed reads with the rate test off and the burst
    // limit at its top: the verdict stays marginal for the whole run.
    program_regs(16'hFFFF, 16'd0, 16'd4096, 1'b0);
    idle_enable <= 1'b0;
    send_sample(elsm_pkg::CMD_CLEAR, READ_OK, 12'd0, 0, 1'b1, CLEARED);
    for (int k = 0; k < LONG_FAIL_RUN; k++)
      send_sample(elsm_pkg::CMD_SAMPLE, READ_FAILED, elsm_pkg::ANGLE_W'($urandom), 0,
                  1'b0, UNTYPED);
    run_link_traffic(180, 40, 10, 1'b1, 1'b0);

    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d samples (%0d clears) over %0d register settings, %0d reports checked",
             samples_sent, clears_sent, settings_applied + 1, reports_checked);
    $display("verdicts %0d stable, %0d unstable, %0d marginal; input back-pressured %0d cycles",
             seen_stable, seen_unstable, seen_marginal, input_held_cycles);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("encoder_link_stability_monitor: match");
    else
      $display("encoder_link_stability_monitor: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("encoder_link_stability_monitor: mismatch");
    $finish;
  end

endmodule
